>>> src/assert_macros.svh
// assertion macros for the distance matrix block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

>>> src/hdm_pkg.sv
// package: types, constants and register codes for the distance matrix block
package hdm_pkg;
  localparam int unsigned MaxRowsDef    = 64;
  localparam int unsigned MaxColsDef    = 8;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned SumW          = 22;
  localparam int unsigned OneQ16        = 65536;

  typedef enum logic [1:0] {
    REG_ROWS   = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_COLS = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic        action;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  a_column;
    logic [2:0]  b_column;
    logic [16:0] distance;
    logic        zero_column;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_req_t;

  // sequencer control toward the shared units
  typedef enum logic [3:0] {
    ST_LOAD, ST_RT_RD, ST_RT_DIV, ST_RT_SQ, ST_PR_RD, ST_PR_MAC,
    ST_PR_SQ, ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
  } unit_ctl_t;
endpackage

>>> src/hdm_divider.sv
// iterative restoring divider: floor((v << 32) / total), one quotient bit per cycle
module hdm_divider #(
  parameter int unsigned SampleBits = hdm_pkg::SampleBitsDef,
  parameter int unsigned SumBits    = hdm_pkg::SumW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SampleBits-1:0] num_i,
  input  logic [SumBits-1:0]    den_i,
  output logic                  done_o,
  output logic [32:0]           quot_o
);
  import hdm_pkg::*;
  localparam int unsigned NumW = SampleBits + 32;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]  num_q, num_d;
  logic [SumBits:0] rem_q, rem_d;
  logic [NumW-1:0]  quo_q, quo_d;
  logic [SumBits-1:0] den_q, den_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d, done_q, done_d;
  logic [SumBits+1:0] trial;

  always_comb begin
    num_d = num_q; rem_d = rem_q; quo_d = quo_q; den_d = den_q;
    cnt_d = cnt_q; run_d = run_q; done_d = 1'b0;
    trial = {rem_q, num_q[NumW-1]} - {2'b0, den_q};
    if (start_i) begin
      num_d = {num_i, 32'd0};
      rem_d = '0;
      quo_d = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
      run_d = 1'b1;
    end else if (run_q) begin
      if (!trial[SumBits+1]) begin
        rem_d = trial[SumBits:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[SumBits-1:0], num_q[NumW-1]};
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      num_d = {num_q[NumW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end

  // clamp to 1.0 in Q1.32
  assign quot_o = (|quo_q[NumW-1:33] || (quo_q[32] && |quo_q[31:0])) ? 33'h1_0000_0000
                : quo_q[32:0];
  assign done_o = done_q;
endmodule

>>> src/hdm_sqrt.sv
// iterative integer square root, one result bit per cycle
module hdm_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] x_i,
  output logic        done_o,
  output logic [23:0] root_o
);
  import hdm_pkg::*;
  logic [47:0] x_q, x_d;
  logic [47:0] res_q, res_d;
  logic [47:0] bit_q, bit_d;
  logic        run_q, run_d, done_q, done_d;

  always_comb begin
    x_d = x_q; res_d = res_q; bit_d = bit_q; run_d = run_q; done_d = 1'b0;
    if (start_i) begin
      x_d = x_i;
      res_d = '0;
      bit_d = 48'd1 << 46;
      run_d = 1'b1;
    end else if (run_q) begin
      if (x_q >= res_q + bit_q) begin
        x_d = x_q - (res_q + bit_q);
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        run_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; res_q <= res_d; bit_q <= bit_d;
  end

  assign root_o = res_q[23:0];
  assign done_o = done_q;
endmodule

>>> src/hellinger_distance_matrix_core.sv
// top level: hellinger distance matrix between columns of two count matrices
//
// input channel (in_valid_i / in_stall_o / in_data_i): one matrix element per
// request, column-major, action selects matrix a (0) or b (1). while loading, an
// element is taken every cycle. elements for a full matrix are dropped.
// once both matrices are complete the block stalls input and computes: each
// element's normalized root takes one divide plus a square root, then each a/b
// pair takes a multiply-accumulate per row through one shared multiplier plus
// a square root. results leave on the output channel (out_valid_o /
// out_stall_i / out_data_o), a column outer, b column inner; last_result
// marks the final pair. a stall on the output holds the result register and
// pauses the sequencer before its next result.
// configuration (cfg_valid_i / cfg_ready_o / cfg_req_i) sets rows and column
// counts (low 7 / 4 data bits); write only while idle. they clamp to 1..max.
// reset clears counts and sums and sets sizes to max; stores are not cleared.
// the square root unit serves the element and pair steps; the divider serves the element steps.
module hellinger_distance_matrix_core
  import hdm_pkg::*;
#(
  parameter int unsigned MaxRows    = MaxRowsDef,
  parameter int unsigned MaxCols    = MaxColsDef,
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hdm_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hdm_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  hdm_pkg::cfg_req_t   cfg_req_i
);
  `include "assert_macros.svh"

  localparam int unsigned RowW    = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int unsigned ColW    = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int unsigned AddrW   = RowW + ColW;
  localparam int unsigned Depth   = 1 << AddrW;
  localparam int unsigned SumBits = SampleBits + RowW;

  state_e state_q, state_d;

  logic [6:0] rows_cfg_q;
  logic [3:0] ac_cfg_q, bc_cfg_q;
  logic [RowW:0] rows;
  logic [ColW:0] acols, bcols;

  // clamp the configured sizes
  always_comb begin
    if (rows_cfg_q == 7'd0) rows = (RowW+1)'(1);
    else if (32'(rows_cfg_q) > MaxRows) rows = (RowW+1)'(MaxRows);
    else rows = (RowW+1)'(rows_cfg_q);
    if (ac_cfg_q == 4'd0) acols = (ColW+1)'(1);
    else if (32'(ac_cfg_q) > MaxCols) acols = (ColW+1)'(MaxCols);
    else acols = (ColW+1)'(ac_cfg_q);
    if (bc_cfg_q == 4'd0) bcols = (ColW+1)'(1);
    else if (32'(bc_cfg_q) > MaxCols) bcols = (ColW+1)'(MaxCols);
    else bcols = (ColW+1)'(bc_cfg_q);
  end

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= 7'(MaxRows);
      ac_cfg_q <= 4'(MaxCols);
      bc_cfg_q <= 4'(MaxCols);
    end else if (cfg_valid_i) begin
      case (cfg_req_i.index)
        REG_ROWS:   rows_cfg_q <= cfg_req_i.data[6:0];
        REG_A_COLS: ac_cfg_q <= cfg_req_i.data[3:0];
        REG_B_COLS: bc_cfg_q <= cfg_req_i.data[3:0];
        default: ;
      endcase
    end
  end

  // load position per matrix: column and row counters
  logic [ColW:0] a_col_q, b_col_q;
  logic [RowW:0] a_row_q, b_row_q;
  logic [SumBits-1:0] a_sum_q [MaxCols];
  logic [SumBits-1:0] b_sum_q [MaxCols];
  logic a_full, b_full;
  assign a_full = (a_col_q >= acols);
  assign b_full = (b_col_q >= bcols);

  // no request is taken once both sets are complete, the burst owns them
  logic in_take;
  assign in_stall_o = (state_q != ST_LOAD) || (a_full && b_full);
  assign in_take = in_valid_i && !in_stall_o;

  logic [SampleBits-1:0] sample;
  assign sample = SampleBits'(in_data_i.value);

  // value and root stores
  logic [SampleBits-1:0] a_mem [Depth];
  logic [SampleBits-1:0] b_mem [Depth];
  logic [16:0] ar_mem [Depth];
  logic [16:0] br_mem [Depth];

  logic wr_a, wr_b;
  logic [AddrW-1:0] wa_addr, wb_addr;
  assign wr_a = in_take && !in_data_i.action && !a_full;
  assign wr_b = in_take && in_data_i.action && !b_full;
  assign wa_addr = {a_col_q[ColW-1:0], a_row_q[RowW-1:0]};
  assign wb_addr = {b_col_q[ColW-1:0], b_row_q[RowW-1:0]};

  // compute sequencer indices
  logic          side_q, side_d;     // 0 = a, 1 = b
  logic [ColW:0] ci_q, ci_d, cj_q, cj_d;
  logic [RowW:0] r_q, r_d;
  logic [47:0]   acc_q, acc_d;
  logic [16:0]   x_q, y_q;
  logic [SampleBits-1:0] v_q;
  logic [AddrW-1:0] rd_a, rd_b;

  always_ff @(posedge clk_i) begin
    if (wr_a) a_mem[wa_addr] <= sample;
    if (wr_b) b_mem[wb_addr] <= sample;
    v_q <= side_q ? b_mem[rd_a] : a_mem[rd_a];
    x_q <= ar_mem[rd_a];
    y_q <= br_mem[rd_b];
  end

  assign rd_a = {ci_q[ColW-1:0], r_q[RowW-1:0]};
  assign rd_b = {cj_q[ColW-1:0], r_q[RowW-1:0]};

  // shared units
  logic div_start, div_done, sq_start, sq_done;
  logic [32:0] quot;
  logic [23:0] root;
  logic [47:0] sq_in;
  logic [SumBits-1:0] cur_sum;
  logic pr_sq_start_q;
  logic sq_go;
  logic [47:0] sq_x;
  assign cur_sum = side_q ? b_sum_q[ci_q[ColW-1:0]] : a_sum_q[ci_q[ColW-1:0]];

  hdm_divider #(.SampleBits(SampleBits), .SumBits(SumBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(v_q), .den_i(cur_sum),
    .done_o(div_done), .quot_o(quot)
  );
  hdm_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_go), .x_i(sq_x), .done_o(sq_done), .root_o(root)
  );

  logic root_we;
  logic [16:0] diff;
  logic [33:0] diff_sq;
  assign diff = (x_q >= y_q) ? (x_q - y_q) : (y_q - x_q);
  assign diff_sq = diff * diff;
  assign root_we = (state_q == ST_RT_SQ) && sq_done;

  always_ff @(posedge clk_i) begin
    if (root_we && !side_q) ar_mem[rd_a] <= (cur_sum == '0) ? 17'd0 : root[16:0];
    if (root_we && side_q)  br_mem[rd_a] <= (cur_sum == '0) ? 17'd0 : root[16:0];
  end

  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic        clear_sets;
  logic        last_row, last_i, last_j, last_rt_col;

  assign last_row    = (r_q == rows - 1'b1);
  assign last_i      = (ci_q == acols - 1'b1);
  assign last_j      = (cj_q == bcols - 1'b1);
  assign last_rt_col = side_q ? (ci_q == bcols - 1'b1) : last_i;

  always_comb begin
    state_d = state_q; side_d = side_q; ci_d = ci_q; cj_d = cj_q; r_d = r_q;
    acc_d = acc_q; div_start = 1'b0; sq_start = 1'b0; sq_in = '0;
    out_valid_d = out_valid_q && out_stall_i; out_d = out_q; clear_sets = 1'b0;
    case (state_q)
      ST_LOAD: begin
        side_d = 1'b0; ci_d = '0; cj_d = '0; r_d = '0;
        if (a_full && b_full) state_d = ST_RT_RD;
      end
      ST_RT_RD: state_d = ST_RT_DIV;
      ST_RT_DIV: begin
        div_start = 1'b1;
        state_d = ST_RT_SQ;
      end
      ST_RT_SQ: begin
        if (div_done) begin
          sq_start = 1'b1;
          sq_in = {15'd0, quot};
        end
        if (sq_done) begin
          state_d = ST_RT_RD;
          if (last_row) begin
            r_d = '0;
            if (last_rt_col) begin
              ci_d = '0;
              if (side_q) begin
                side_d = 1'b0;
                state_d = ST_PR_RD;
              end else side_d = 1'b1;
            end else ci_d = ci_q + 1'b1;
          end else r_d = r_q + 1'b1;
        end
      end
      ST_PR_RD: begin
        // fresh sum at the first row of a pair
        if (r_q == '0) acc_d = '0;
        state_d = ST_PR_MAC;
      end
      ST_PR_MAC: begin
        acc_d = acc_q + 48'(diff_sq);
        if (last_row) begin
          r_d = '0;
          state_d = ST_PR_SQ;
        end else begin
          r_d = r_q + 1'b1;
          state_d = ST_PR_RD;
        end
      end
      ST_PR_SQ: begin
        if (sq_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d.a_column = 3'(ci_q);
          out_d.b_column = 3'(cj_q);
          out_d.distance = (root > 24'(OneQ16)) ? 17'(OneQ16) : root[16:0];
          out_d.zero_column = (a_sum_q[ci_q[ColW-1:0]] == '0) ||
                              (b_sum_q[cj_q[ColW-1:0]] == '0);
          out_d.last_result = last_i && last_j;
          state_d = ST_PR_RD;
          if (last_j) begin
            cj_d = '0;
            if (last_i) begin
              state_d = ST_LOAD;
              clear_sets = 1'b1;
            end else ci_d = ci_q + 1'b1;
          end else cj_d = cj_q + 1'b1;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // root start for a pair comes on entry to ST_PR_SQ
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pr_sq_start_q <= 1'b0;
    else pr_sq_start_q <= (state_q == ST_PR_MAC) && last_row;
  end
  assign sq_go = sq_start || pr_sq_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      side_q <= 1'b0;
      ci_q <= '0; cj_q <= '0; r_q <= '0;
      out_valid_q <= 1'b0;
      a_col_q <= '0; b_col_q <= '0; a_row_q <= '0; b_row_q <= '0;
      for (int k = 0; k < MaxCols; k++) begin
        a_sum_q[k] <= '0;
        b_sum_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      side_q <= side_d;
      ci_q <= ci_d; cj_q <= cj_d; r_q <= r_d;
      out_valid_q <= out_valid_d;
      if (clear_sets) begin
        a_col_q <= '0; b_col_q <= '0; a_row_q <= '0; b_row_q <= '0;
        for (int k = 0; k < MaxCols; k++) begin
          a_sum_q[k] <= '0;
          b_sum_q[k] <= '0;
        end
      end else begin
        if (wr_a) begin
          a_sum_q[a_col_q[ColW-1:0]] <= a_sum_q[a_col_q[ColW-1:0]] + SumBits'(sample);
          if (a_row_q == rows - 1'b1) begin
            a_row_q <= '0;
            a_col_q <= a_col_q + 1'b1;
          end else a_row_q <= a_row_q + 1'b1;
        end
        if (wr_b) begin
          b_sum_q[b_col_q[ColW-1:0]] <= b_sum_q[b_col_q[ColW-1:0]] + SumBits'(sample);
          if (b_row_q == rows - 1'b1) begin
            b_row_q <= '0;
            b_col_q <= b_col_q + 1'b1;
          end else b_row_q <= b_row_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    out_q <= out_d;
  end

  // the sqrt unit sees either the ratio or half the pair sum
  assign sq_x = pr_sq_start_q ? (acc_q >> 1) : sq_in;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_CLK(a_no_take_busy, clk_i, rst_ni, !(in_take && state_q != ST_LOAD),
              "input taken while computing")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && out_stall_i,
               out_valid_q && $stable(out_q), "result dropped under stall")
  `ASSERT_CLK(a_load_bound, clk_i, rst_ni, a_col_q <= (ColW+1)'(MaxCols),
              "load counter overran")
endmodule
